### rtl/core/tick_driven_calendar_clock_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tick-driven calendar clock
// Shared helpers that wrap concurrent assertions clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef TICK_DRIVEN_CALENDAR_CLOCK_TOP_DEFINES_SVH
`define TICK_DRIVEN_CALENDAR_CLOCK_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDCC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("calendar clock assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TDCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("calendar clock assertion failed");

`endif

### rtl/core/tdcc_pkg.sv
// ----------------------------------------------------------------------------
// Calendar clock package
// Field widths, register indexes, calendar limits and the month length table.
// ----------------------------------------------------------------------------
package tdcc_pkg;

    localparam int unsigned TPS_W     = 20;
    localparam int unsigned FEB_W     = 5;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 20;
    localparam int unsigned PULSE_W   = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEBRUARY_DAYS    = 1'd1;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam logic [TPS_W-1:0] TPS_RESET = 20'd1000;
    localparam logic [FEB_W-1:0] FEB_RESET = 5'd28;

    localparam logic [5:0] SECOND_LAST  = 6'd59;
    localparam logic [5:0] MINUTE_LAST  = 6'd59;
    localparam logic [4:0] HOUR_LAST    = 5'd23;
    localparam logic [2:0] WEEKDAY_LAST = 3'd7;
    localparam logic [3:0] MONTH_LAST   = 4'd12;
    localparam logic [6:0] YEAR_LAST    = 7'd99;
    localparam logic [3:0] MONTH_FEB    = 4'd2;

    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [2:0] weekday;
    } t_cal;

    // Standard month lengths; month codes outside 1 to 12 count as 31 days.
    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] len;
        unique case (month)
            4'd2:                      len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

### rtl/core/tdcc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Calendar clock configuration registers
// Holds the ticks-per-second prescale value and the length of February.
// ----------------------------------------------------------------------------
module tdcc_cfg_regs
    import tdcc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output logic [TPS_W-1:0]     o_ticks_per_second,
    output logic [FEB_W-1:0]     o_february_days
);

    logic [TPS_W-1:0] r_tps;
    logic [FEB_W-1:0] r_feb;

    assign o_cfg_ready        = 1'b1;
    assign o_ticks_per_second = r_tps;
    assign o_february_days    = r_feb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= TPS_RESET;
            r_feb <= FEB_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TICKS_PER_SECOND: r_tps <= i_cfg_data[TPS_W-1:0];
                CFG_FEBRUARY_DAYS:    r_feb <= i_cfg_data[FEB_W-1:0];
                default:              r_tps <= r_tps;
            endcase
        end
    end

endmodule

### rtl/core/tdcc_calendar.sv
// ----------------------------------------------------------------------------
// Calendar clock counter chain
// Prescaler and the second to year cascade, advanced once per fired item.
// ----------------------------------------------------------------------------
module tdcc_calendar
    import tdcc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic               i_cmd,
    input  t_cal               i_set,
    input  logic [TPS_W-1:0]   i_ticks_per_second,
    input  logic [FEB_W-1:0]   i_february_days,
    output t_cal               o_next,
    output logic [PULSE_W-1:0] o_pulses
);

    logic [TPS_W-1:0] r_presc;
    logic [TPS_W-1:0] n_presc;
    t_cal             r_cal;
    t_cal             n_cal;
    logic [PULSE_W-1:0] n_pulses;
    logic [TPS_W-1:0] w_last;
    logic [4:0]       w_mlen;

    // A prescale value of zero behaves as one: every tick is a second.
    assign w_last = (i_ticks_per_second == '0) ? '0 : i_ticks_per_second - 1'b1;
    assign w_mlen = (r_cal.month == MONTH_FEB) ? i_february_days : month_len(r_cal.month);

    always_comb begin
        n_cal    = r_cal;
        n_presc  = r_presc;
        n_pulses = '0;
        if (i_cmd == CMD_LOAD) begin
            n_cal   = i_set;
            n_presc = '0;
        end else if (r_presc < w_last) begin
            n_presc = r_presc + 1'b1;
        end else begin
            n_presc     = '0;
            n_pulses[0] = 1'b1;
            if (r_cal.second < SECOND_LAST) begin
                n_cal.second = r_cal.second + 1'b1;
            end else begin
                n_cal.second = '0;
                n_pulses[1] = 1'b1;
                if (r_cal.minute < MINUTE_LAST) begin
                    n_cal.minute = r_cal.minute + 1'b1;
                end else begin
                    n_cal.minute = '0;
                    n_pulses[2] = 1'b1;
                    if (r_cal.hour < HOUR_LAST) begin
                        n_cal.hour = r_cal.hour + 1'b1;
                    end else begin
                        n_cal.hour  = '0;
                        n_pulses[3] = 1'b1;
                        n_cal.weekday = (r_cal.weekday < WEEKDAY_LAST) ?
                                        r_cal.weekday + 1'b1 : 3'd1;
                        if (r_cal.day < w_mlen) begin
                            n_cal.day = r_cal.day + 1'b1;
                        end else begin
                            n_cal.day   = 5'd1;
                            n_pulses[4] = 1'b1;
                            if (r_cal.month < MONTH_LAST) begin
                                n_cal.month = r_cal.month + 1'b1;
                            end else begin
                                n_cal.month = 4'd1;
                                n_pulses[5] = 1'b1;
                                n_cal.year  = (r_cal.year < YEAR_LAST) ?
                                              r_cal.year + 1'b1 : '0;
                            end
                        end
                    end
                end
            end
        end
    end

    assign o_next   = n_cal;
    assign o_pulses = n_pulses;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_presc       <= '0;
            r_cal.year    <= '0;
            r_cal.month   <= 4'd1;
            r_cal.day     <= 5'd1;
            r_cal.hour    <= '0;
            r_cal.minute  <= '0;
            r_cal.second  <= '0;
            r_cal.weekday <= 3'd1;
        end else if (i_fire) begin
            r_presc <= n_presc;
            r_cal   <= n_cal;
        end
    end

endmodule

### rtl/core/tick_driven_calendar_clock_top.sv
// ----------------------------------------------------------------------------
// Tick-driven calendar clock
// Each accepted item is either one system tick or a load of the whole
// calendar, and returns exactly one result: the calendar after the item and
// one rollover pulse per level. The block takes one item every clock cycle
// while o_stall is low. An accepted item is held in the input register and
// then passes through the counter cascade into the result register. The
// prescaler and the carry chain from seconds to years are evaluated
// combinationally between those two registers, which sets that throughput.
// A result that is held by a stall on the output side stops the input only
// once the input register is also full. Configuration writes are always
// ready.
// ----------------------------------------------------------------------------
`include "tick_driven_calendar_clock_top_defines.svh"

module tick_driven_calendar_clock_top
    import tdcc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Item input
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_cmd,
    input  logic [6:0]           i_set_year,
    input  logic [3:0]           i_set_month,
    input  logic [4:0]           i_set_day,
    input  logic [4:0]           i_set_hour,
    input  logic [5:0]           i_set_minute,
    input  logic [5:0]           i_set_second,
    input  logic [2:0]           i_set_weekday,
    // Result output
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [6:0]           o_now_year,
    output logic [3:0]           o_now_month,
    output logic [4:0]           o_now_day,
    output logic [4:0]           o_now_hour,
    output logic [5:0]           o_now_minute,
    output logic [5:0]           o_now_second,
    output logic [2:0]           o_now_weekday,
    output logic [PULSE_W-1:0]   o_rollover_pulses,
    // Configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    logic               r_in_valid;
    logic               r_in_cmd;
    t_cal               r_in_set;
    logic               r_out_valid;
    t_cal               r_out_cal;
    logic [PULSE_W-1:0] r_out_pulses;

    logic               w_out_blocked;
    logic               w_fire;
    logic               w_accept;
    t_cal               w_next;
    logic [PULSE_W-1:0] w_pulses;
    logic [TPS_W-1:0]   w_tps;
    logic [FEB_W-1:0]   w_feb;

    assign w_out_blocked = r_out_valid && i_stall;
    assign w_fire        = r_in_valid && !w_out_blocked;
    assign o_stall       = r_in_valid && w_out_blocked;
    assign w_accept      = i_valid && !o_stall;

    tdcc_cfg_regs u_cfg (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_ticks_per_second (w_tps),
        .o_february_days    (w_feb)
    );

    tdcc_calendar u_cal (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_fire             (w_fire),
        .i_cmd              (r_in_cmd),
        .i_set              (r_in_set),
        .i_ticks_per_second (w_tps),
        .i_february_days    (w_feb),
        .o_next             (w_next),
        .o_pulses           (w_pulses)
    );

    // Control state of both register stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_cmd         <= i_cmd;
            r_in_set.year    <= i_set_year;
            r_in_set.month   <= i_set_month;
            r_in_set.day     <= i_set_day;
            r_in_set.hour    <= i_set_hour;
            r_in_set.minute  <= i_set_minute;
            r_in_set.second  <= i_set_second;
            r_in_set.weekday <= i_set_weekday;
        end
        if (w_fire) begin
            r_out_cal    <= w_next;
            r_out_pulses <= w_pulses;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_now_year        = r_out_cal.year;
    assign o_now_month       = r_out_cal.month;
    assign o_now_day         = r_out_cal.day;
    assign o_now_hour        = r_out_cal.hour;
    assign o_now_minute      = r_out_cal.minute;
    assign o_now_second      = r_out_cal.second;
    assign o_now_weekday     = r_out_cal.weekday;
    assign o_rollover_pulses = r_out_pulses;

    // A new item may enter a full input register only when that item moves on.
    `TDCC_ASSERT_SAME(a_accept_needs_fire, i_clk, i_rst_n,
        w_accept && r_in_valid, w_fire)
    // Rollover pulses are nested: a level only rolls when the level below rolls.
    `TDCC_ASSERT_SAME(a_pulse_nesting, i_clk, i_rst_n, o_valid,
        (!o_rollover_pulses[1] || o_rollover_pulses[0]) &&
        (!o_rollover_pulses[2] || o_rollover_pulses[1]) &&
        (!o_rollover_pulses[3] || o_rollover_pulses[2]) &&
        (!o_rollover_pulses[4] || o_rollover_pulses[3]) &&
        (!o_rollover_pulses[5] || o_rollover_pulses[4]))
    // A minute rollover leaves the seconds at zero.
    `TDCC_ASSERT_SAME(a_minute_roll_zero_sec, i_clk, i_rst_n,
        o_valid && o_rollover_pulses[1], o_now_second == 6'd0)
    // A fired item always produces a visible result in the next cycle.
    `TDCC_ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n, w_fire, o_valid)

endmodule
